[hw/rtl/olsb_pkg.sv]
// Shared types, constants and geometry helpers of the segment builder.
// Used by olsb_cmp and by the top level optimal_linear_segment_builder.
`default_nettype none
package olsb_pkg;

   localparam int HULL_DEPTH = 1024;
   localparam int HULL_AW    = $clog2(HULL_DEPTH);
   localparam int HULL_LW    = $clog2(HULL_DEPTH + 1);

   localparam logic [31:0] ERROR_BOUND_RESET = 32'd15;

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_CLOSE  = 2'd1;
   localparam logic [1:0] ST_ORDER  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [63:0] x;
      logic [63:0] y;
   } pt_type;

   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
   } sv_type;

   typedef struct packed {
      sv_type dx;
      sv_type dy;
   } grad_type;

   // The comparator returns the sign of a*b - c*d.
   typedef struct packed {
      logic   start;
      sv_type a;
      sv_type b;
      sv_type c;
      sv_type d;
   } cmp_req_type;

   typedef struct packed {
      logic done;
      logic lt;
      logic gt;
   } cmp_rsp_type;

   function automatic sv_type sdiff(input logic [63:0] a, input logic [63:0] b);
      sv_type r;
      if (a >= b) begin
         r.neg = 1'b0;
         r.mag = a - b;
      end else begin
         r.neg = 1'b1;
         r.mag = b - a;
      end
      return r;
   endfunction

   function automatic grad_type gsub(input pt_type a, input pt_type b);
      grad_type g;
      g.dx = sdiff(a.x, b.x);
      g.dy = sdiff(a.y, b.y);
      return g;
   endfunction

   // Slope order of p against q: sign of p.dy*q.dx - p.dx*q.dy.
   function automatic cmp_req_type grad_req(input grad_type p, input grad_type q);
      cmp_req_type r;
      r.start = 1'b1;
      r.a     = p.dy;
      r.b     = q.dx;
      r.c     = p.dx;
      r.d     = q.dy;
      return r;
   endfunction

   // Turn direction of o -> a -> b.
   function automatic cmp_req_type turn_req(input pt_type o, input pt_type a,
                                            input pt_type b);
      cmp_req_type r;
      grad_type    oa;
      grad_type    ob;
      oa      = gsub(a, o);
      ob      = gsub(b, o);
      r.start = 1'b1;
      r.a     = oa.dx;
      r.b     = ob.dy;
      r.c     = oa.dy;
      r.d     = ob.dx;
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/olsb_cmp.sv]
// Exact comparator of two signed 64x64 products, one 32x32 partial product
// per product and cycle. Depends on olsb_pkg.
`default_nettype none
module olsb_cmp
   import olsb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmp_req_type req,
   output      cmp_rsp_type rsp
);

   localparam logic [2:0] LAST = 3'd5;

   logic         busy_ff, busy_in;
   logic [2:0]   cnt_ff, cnt_in;
   sv_type       opa_ff, opb_ff, opc_ff, opd_ff;
   logic [63:0]  prod1_ff, prod2_ff;
   logic [1:0]   psel_ff;
   logic         pvld_ff, pvld_in;
   logic [127:0] acc1_ff, acc2_ff;

   logic [31:0]  a_half, b_half, c_half, d_half;
   logic [6:0]   shamt;
   logic [127:0] add1, add2;
   logic         nz1, nz2;
   logic [1:0]   rank1, rank2;

   assign a_half = cnt_ff[1] ? opa_ff.mag[63:32] : opa_ff.mag[31:0];
   assign b_half = cnt_ff[0] ? opb_ff.mag[63:32] : opb_ff.mag[31:0];
   assign c_half = cnt_ff[1] ? opc_ff.mag[63:32] : opc_ff.mag[31:0];
   assign d_half = cnt_ff[0] ? opd_ff.mag[63:32] : opd_ff.mag[31:0];

   always_comb begin
      unique case (psel_ff)
         2'd0:    shamt = 7'd0;
         2'd3:    shamt = 7'd64;
         default: shamt = 7'd32;
      endcase
   end

   assign add1 = {64'd0, prod1_ff} << shamt;
   assign add2 = {64'd0, prod2_ff} << shamt;

   assign busy_in = req.start | (busy_ff & (cnt_ff != LAST));
   assign cnt_in  = req.start ? 3'd0 : ((busy_ff && cnt_ff != LAST) ? cnt_ff + 3'd1 : cnt_ff);
   assign pvld_in = busy_ff & ~req.start & (cnt_ff < 3'd4);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
         pvld_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         pvld_ff <= pvld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         opa_ff  <= req.a;
         opb_ff  <= req.b;
         opc_ff  <= req.c;
         opd_ff  <= req.d;
         acc1_ff <= '0;
         acc2_ff <= '0;
      end else begin
         if (pvld_ff) begin
            acc1_ff <= acc1_ff + add1;
            acc2_ff <= acc2_ff + add2;
         end
      end
      prod1_ff <= a_half * b_half;
      prod2_ff <= c_half * d_half;
      psel_ff  <= cnt_ff[1:0];
   end

   // Rank 0 is negative, 1 zero, 2 positive.
   assign nz1   = |acc1_ff;
   assign nz2   = |acc2_ff;
   assign rank1 = !nz1 ? 2'd1 : ((opa_ff.neg ^ opb_ff.neg) ? 2'd0 : 2'd2);
   assign rank2 = !nz2 ? 2'd1 : ((opc_ff.neg ^ opd_ff.neg) ? 2'd0 : 2'd2);

   always_comb begin
      rsp.done = busy_ff && (cnt_ff == LAST);
      rsp.lt   = 1'b0;
      rsp.gt   = 1'b0;
      if (rank1 != rank2) begin
         rsp.lt = rank1 < rank2;
         rsp.gt = rank1 > rank2;
      end else if (rank1 == 2'd2) begin
         rsp.lt = acc1_ff < acc2_ff;
         rsp.gt = acc1_ff > acc2_ff;
      end else if (rank1 == 2'd0) begin
         rsp.lt = acc1_ff > acc2_ff;
         rsp.gt = acc1_ff < acc2_ff;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/optimal_linear_segment_builder.sv]
// Top level of the segment builder: sequencer, hull memories, corner registers.
// Depends on olsb_pkg and olsb_cmp.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_key, req_position
//   rsp      out        rsp_valid/stall    rsp_status .. rsp_corner3_y
//   csr      in         csr_valid/ready    csr_error_bound
//
// An out-of-order key goes straight to the result, as does one of a segment's first
// two points after dispatch. Other items run exact slope or turn comparisons, hull
// phases, hull entry searches and pops in turn, on the 64x64 product comparator
// and through the single read port of each hull memory.
// Reset is synchronous; hull memories are not cleared, and are read only
// where written. The next item is accepted while a result waits on rsp_stall.
`default_nettype none
module optimal_linear_segment_builder
   import olsb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [63:0] req_key,
   input  wire logic [63:0] req_position,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [31:0] rsp_segment_points,
   output      logic [63:0] rsp_first_key,
   output      logic [63:0] rsp_corner0_x,
   output      logic [63:0] rsp_corner0_y,
   output      logic [63:0] rsp_corner1_x,
   output      logic [63:0] rsp_corner1_y,
   output      logic [63:0] rsp_corner2_x,
   output      logic [63:0] rsp_corner2_y,
   output      logic [63:0] rsp_corner3_x,
   output      logic [63:0] rsp_corner3_y,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [31:0] csr_error_bound
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DISP   = 5'd1;
   localparam logic [4:0] S_TAW    = 5'd2;
   localparam logic [4:0] S_TBW    = 5'd3;
   localparam logic [4:0] S_TCW    = 5'd4;
   localparam logic [4:0] S_TDW    = 5'd5;
   localparam logic [4:0] S_HSTART = 5'd6;
   localparam logic [4:0] S_HRD    = 5'd7;
   localparam logic [4:0] S_HGET   = 5'd8;
   localparam logic [4:0] S_HCW    = 5'd9;
   localparam logic [4:0] S_HNEXT  = 5'd10;
   localparam logic [4:0] S_HDONE  = 5'd11;
   localparam logic [4:0] S_PCHK   = 5'd12;
   localparam logic [4:0] S_PRD1   = 5'd13;
   localparam logic [4:0] S_PRD2   = 5'd14;
   localparam logic [4:0] S_PGET   = 5'd15;
   localparam logic [4:0] S_PCW    = 5'd16;
   localparam logic [4:0] S_PUSH   = 5'd17;
   localparam logic [4:0] S_FIN    = 5'd18;
   localparam logic [4:0] S_EMIT   = 5'd19;

   localparam logic [63:0] TOP_V = '1;

   logic [4:0]         state_ff, state_in;
   logic [31:0]        eb_ff, eb_in;
   logic [63:0]        key_ff, key_in;
   logic [63:0]        top_y_ff, top_y_in;
   logic [63:0]        bot_y_ff, bot_y_in;
   logic [63:0]        prev_key_ff, prev_key_in;
   logic [63:0]        first_key_ff, first_key_in;
   logic [31:0]        pc_ff, pc_in;
   pt_type             corner_ff [4];
   pt_type             corner_in [4];
   pt_type             snap_ff [4];
   pt_type             snap_in [4];
   logic [HULL_AW-1:0] ubase_ff, ubase_in, lbase_ff, lbase_in;
   logic [HULL_LW-1:0] ulen_ff, ulen_in, llen_ff, llen_in;
   logic [HULL_LW-1:0] pend_ff, pend_in, idx_ff, idx_in;
   logic               side_ff, side_in, first_ff, first_in, full_ff, full_in;
   pt_type             best_ff, best_in, cand_ff, cand_in, pa_ff, pa_in;
   logic [HULL_AW-1:0] best_idx_ff, best_idx_in;
   logic [1:0]         st_ff, st_in;
   cmp_req_type        cmp_req_ff, cmp_req_in;
   cmp_rsp_type        cmp_rsp;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic [1:0]         rsp_status_ff;
   logic [31:0]        rsp_points_ff;
   logic [63:0]        rsp_first_key_ff;
   pt_type             rsp_corner_ff [4];

   pt_type             upper_mem [HULL_DEPTH];
   pt_type             lower_mem [HULL_DEPTH];
   pt_type             up_rd_ff, lo_rd_ff;
   logic [HULL_AW-1:0] rd_addr, up_waddr, lo_waddr;
   logic               up_we, lo_we;
   pt_type             up_wdata, lo_wdata;

   pt_type             top_pt, bot_pt, piv, srch_rd, push_rd;
   logic [63:0]        eb_wide;
   logic [HULL_AW-1:0] pop_base;
   logic [HULL_LW-1:0] srch_len;

   olsb_cmp u_cmp (
      .clock (clock),
      .reset (reset),
      .req   (cmp_req_ff),
      .rsp   (cmp_rsp)
   );

   assign top_pt   = '{x: key_ff, y: top_y_ff};
   assign bot_pt   = '{x: key_ff, y: bot_y_ff};
   assign piv      = side_ff ? bot_pt : top_pt;
   // Phase 0 searches the lower hull and pushes on the upper; phase 1 the reverse.
   assign srch_rd  = side_ff ? up_rd_ff : lo_rd_ff;
   assign push_rd  = side_ff ? lo_rd_ff : up_rd_ff;
   assign pop_base = side_ff ? lbase_ff : ubase_ff;
   assign srch_len = side_ff ? ulen_ff : llen_ff;
   assign eb_wide  = {32'd0, eb_ff};

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      eb_in        = csr_valid ? csr_error_bound : eb_ff;
      key_in       = key_ff;
      top_y_in     = top_y_ff;
      bot_y_in     = bot_y_ff;
      prev_key_in  = prev_key_ff;
      first_key_in = first_key_ff;
      pc_in        = pc_ff;
      corner_in    = corner_ff;
      snap_in      = snap_ff;
      ubase_in     = ubase_ff;
      lbase_in     = lbase_ff;
      ulen_in      = ulen_ff;
      llen_in      = llen_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      side_in      = side_ff;
      first_in     = first_ff;
      full_in      = full_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      cand_in      = cand_ff;
      pa_in        = pa_ff;
      st_in        = st_ff;
      cmp_req_in   = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr      = idx_ff[HULL_AW-1:0];
      up_we        = 1'b0;
      lo_we        = 1'b0;
      up_waddr     = '0;
      lo_waddr     = '0;
      up_wdata     = top_pt;
      lo_wdata     = bot_pt;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_key;
               top_y_in = (req_position >= TOP_V - eb_wide) ? TOP_V
                                                           : req_position + eb_wide;
               bot_y_in = (req_position <= eb_wide) ? 64'd0 : req_position - eb_wide;
               if (pc_ff != 32'd0 && req_key <= prev_key_ff) begin
                  st_in    = ST_ORDER;
                  state_in = S_EMIT;
               end else begin
                  prev_key_in = req_key;
                  state_in    = S_DISP;
               end
            end
         end
         S_DISP: begin
            full_in = 1'b0;
            if (pc_ff == 32'd0) begin
               first_key_in = key_ff;
               corner_in[0] = top_pt;
               corner_in[1] = bot_pt;
               corner_in[2] = top_pt;
               corner_in[3] = bot_pt;
               up_we        = 1'b1;
               lo_we        = 1'b1;
               ubase_in     = '0;
               lbase_in     = '0;
               ulen_in      = HULL_LW'(1);
               llen_in      = HULL_LW'(1);
               pc_in        = 32'd1;
               st_in        = ST_ACCEPT;
               state_in     = S_EMIT;
            end else if (pc_ff == 32'd1) begin
               corner_in[2] = bot_pt;
               corner_in[3] = top_pt;
               up_we        = 1'b1;
               lo_we        = 1'b1;
               up_waddr     = HULL_AW'(1);
               lo_waddr     = HULL_AW'(1);
               ulen_in      = HULL_LW'(2);
               llen_in      = HULL_LW'(2);
               pc_in        = 32'd2;
               st_in        = ST_ACCEPT;
               state_in     = S_EMIT;
            end else begin
               snap_in    = corner_ff;
               cmp_req_in = grad_req(gsub(top_pt, corner_ff[2]),
                                     gsub(corner_ff[2], corner_ff[0]));
               state_in   = S_TAW;
            end
         end
         S_TAW: begin
            if (cmp_rsp.done) begin
               if (cmp_rsp.lt) begin
                  pc_in    = 32'd0;
                  st_in    = ST_CLOSE;
                  state_in = S_EMIT;
               end else begin
                  cmp_req_in = grad_req(gsub(bot_pt, snap_ff[3]),
                                        gsub(snap_ff[3], snap_ff[1]));
                  state_in   = S_TBW;
               end
            end
         end
         S_TBW: begin
            if (cmp_rsp.done) begin
               if (cmp_rsp.gt) begin
                  pc_in    = 32'd0;
                  st_in    = ST_CLOSE;
                  state_in = S_EMIT;
               end else begin
                  cmp_req_in = grad_req(gsub(top_pt, snap_ff[1]),
                                        gsub(snap_ff[3], snap_ff[1]));
                  state_in   = S_TCW;
               end
            end
         end
         S_TCW: begin
            if (cmp_rsp.done) begin
               if (cmp_rsp.lt) begin
                  side_in  = 1'b0;
                  state_in = S_HSTART;
               end else begin
                  cmp_req_in = grad_req(gsub(bot_pt, snap_ff[0]),
                                        gsub(snap_ff[2], snap_ff[0]));
                  state_in   = S_TDW;
               end
            end
         end
         S_TDW: begin
            if (cmp_rsp.done) begin
               if (cmp_rsp.gt) begin
                  side_in  = 1'b1;
                  state_in = S_HSTART;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_HSTART: begin
            idx_in   = {1'b0, (side_ff ? ubase_ff : lbase_ff)};
            first_in = 1'b1;
            state_in = S_HRD;
         end
         S_HRD: begin
            state_in = S_HGET;
         end
         S_HGET: begin
            if (first_ff) begin
               best_in     = srch_rd;
               best_idx_in = idx_ff[HULL_AW-1:0];
               first_in    = 1'b0;
               idx_in      = idx_ff + HULL_LW'(1);
               state_in    = S_HNEXT;
            end else begin
               cand_in    = srch_rd;
               cmp_req_in = grad_req(gsub(srch_rd, piv), gsub(best_ff, piv));
               state_in   = S_HCW;
            end
         end
         S_HCW: begin
            if (cmp_rsp.done) begin
               // The search stops where the slope to the pivot turns back.
               if (side_ff ? cmp_rsp.lt : cmp_rsp.gt) begin
                  state_in = S_HDONE;
               end else begin
                  best_in     = cand_ff;
                  best_idx_in = idx_ff[HULL_AW-1:0];
                  idx_in      = idx_ff + HULL_LW'(1);
                  state_in    = S_HNEXT;
               end
            end
         end
         S_HNEXT: begin
            state_in = (idx_ff < srch_len) ? S_HRD : S_HDONE;
         end
         S_HDONE: begin
            if (!side_ff) begin
               corner_in[1] = best_ff;
               corner_in[3] = piv;
               lbase_in     = best_idx_ff;
               pend_in      = ulen_ff;
            end else begin
               corner_in[0] = best_ff;
               corner_in[2] = piv;
               ubase_in     = best_idx_ff;
               pend_in      = llen_ff;
            end
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (pend_ff >= {1'b0, pop_base} + HULL_LW'(2)) begin
               state_in = S_PRD1;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PRD1: begin
            rd_addr  = HULL_AW'(pend_ff - HULL_LW'(1));
            state_in = S_PRD2;
         end
         S_PRD2: begin
            pa_in    = push_rd;
            rd_addr  = HULL_AW'(pend_ff - HULL_LW'(2));
            state_in = S_PGET;
         end
         S_PGET: begin
            cmp_req_in = turn_req(push_rd, pa_ff, piv);
            state_in   = S_PCW;
         end
         S_PCW: begin
            if (cmp_rsp.done) begin
               if (side_ff ? !cmp_rsp.lt : !cmp_rsp.gt) begin
                  pend_in  = pend_ff - HULL_LW'(1);
                  state_in = S_PCHK;
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            if (pend_ff >= HULL_LW'(HULL_DEPTH)) begin
               full_in  = 1'b1;
               state_in = S_FIN;
            end else if (!side_ff) begin
               up_we      = 1'b1;
               up_waddr   = pend_ff[HULL_AW-1:0];
               ulen_in    = pend_ff + HULL_LW'(1);
               cmp_req_in = grad_req(gsub(bot_pt, snap_ff[0]),
                                     gsub(snap_ff[2], snap_ff[0]));
               state_in   = S_TDW;
            end else begin
               lo_we    = 1'b1;
               lo_waddr = pend_ff[HULL_AW-1:0];
               llen_in  = pend_ff + HULL_LW'(1);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (full_ff) begin
               corner_in = snap_ff;
               pc_in     = 32'd0;
               st_in     = ST_FULL;
            end else begin
               if (pc_ff != '1) begin
                  pc_in = pc_ff + 32'd1;
               end
               st_in = ST_ACCEPT;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         eb_ff        <= ERROR_BOUND_RESET;
         prev_key_ff  <= '0;
         first_key_ff <= '0;
         pc_ff        <= '0;
         ubase_ff     <= '0;
         lbase_ff     <= '0;
         ulen_ff      <= '0;
         llen_ff      <= '0;
         cmp_req_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            corner_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         eb_ff        <= eb_in;
         prev_key_ff  <= prev_key_in;
         first_key_ff <= first_key_in;
         pc_ff        <= pc_in;
         ubase_ff     <= ubase_in;
         lbase_ff     <= lbase_in;
         ulen_ff      <= ulen_in;
         llen_ff      <= llen_in;
         cmp_req_ff   <= cmp_req_in;
         rsp_valid_ff <= rsp_valid_in;
         corner_ff    <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      top_y_ff    <= top_y_in;
      bot_y_ff    <= bot_y_in;
      snap_ff     <= snap_in;
      pend_ff     <= pend_in;
      idx_ff      <= idx_in;
      side_ff     <= side_in;
      first_ff    <= first_in;
      full_ff     <= full_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      cand_ff     <= cand_in;
      pa_ff       <= pa_in;
      st_ff       <= st_in;
      if (rsp_load) begin
         rsp_status_ff    <= st_ff;
         rsp_points_ff    <= pc_ff;
         rsp_first_key_ff <= first_key_ff;
         rsp_corner_ff    <= corner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (up_we) begin
         upper_mem[up_waddr] <= up_wdata;
      end
      up_rd_ff <= upper_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lo_we) begin
         lower_mem[lo_waddr] <= lo_wdata;
      end
      lo_rd_ff <= lower_mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_segment_points = rsp_points_ff;
   assign rsp_first_key      = rsp_first_key_ff;
   assign rsp_corner0_x      = rsp_corner_ff[0].x;
   assign rsp_corner0_y      = rsp_corner_ff[0].y;
   assign rsp_corner1_x      = rsp_corner_ff[1].x;
   assign rsp_corner1_y      = rsp_corner_ff[1].y;
   assign rsp_corner2_x      = rsp_corner_ff[2].x;
   assign rsp_corner2_y      = rsp_corner_ff[2].y;
   assign rsp_corner3_x      = rsp_corner_ff[3].x;
   assign rsp_corner3_y      = rsp_corner_ff[3].y;

   // The comparator only finishes work that the sequencer waits for.
   a_cmp_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_EMIT) |-> !cmp_rsp.done)
      else $error("comparator finished while no comparison was pending");

   // With a segment open, each hull base lies inside its stack.
   a_hull_base: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != 32'd0 && state_ff == S_IDLE) |->
      ({1'b0, ubase_ff} < ulen_ff && {1'b0, lbase_ff} < llen_ff))
      else $error("hull base outside its stack");

   // An accepted item always starts work.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISP || state_ff == S_EMIT))
      else $error("accepted item did not start work");

endmodule
`default_nettype wire

[verif/tb_optimal_linear_segment_builder.sv]
// Self-checking testbench for optimal_linear_segment_builder: directed and random
// point streams are checked against an in-bench segment predictor. Depends on olsb_pkg and the RTL.
`timescale 1ns / 1ps
module tb_optimal_linear_segment_builder
   import olsb_pkg::*;
;

   localparam int IDLE_LIMIT = 200000;

   typedef struct {
      bit [63:0] x;
      bit [63:0] y;
   } pnt_type;

   typedef struct {
      bit        neg;
      bit [63:0] mag;
   } sm_type;

   typedef struct {
      sm_type dx;
      sm_type dy;
   } dir_type;

   typedef struct packed {
      bit [1:0]        status;
      bit [31:0]       points;
      bit [63:0]       first_key;
      bit [3:0][63:0]  cx;
      bit [3:0][63:0]  cy;
   } seg_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_key = '0;
   logic [63:0] req_position = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_segment_points;
   logic [63:0] rsp_first_key;
   logic [63:0] rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y;
   logic [63:0] rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_error_bound = '0;

   optimal_linear_segment_builder dut (.*);

   always #6 clock = ~clock;

   // Predictor state.
   bit [63:0] band;
   bit [63:0] up_x[HULL_DEPTH], up_y[HULL_DEPTH], lo_x[HULL_DEPTH], lo_y[HULL_DEPTH];
   bit [63:0] cnx[4], cny[4];
   bit [63:0] seg_first, last_key;
   int        up_base, lo_base, up_len, lo_len;
   bit [31:0] seg_count;

   pnt_type        pending_points[$];
   seg_result_type expected_results[$];
   bit             req_took = 1'b0;
   bit             failed = 1'b0;
   bit             burst_mode = 1'b0;
   bit [63:0]      key_cursor = 0;
   int             idle_cycles = 0;

   function automatic sm_type signed_diff(bit [63:0] a, bit [63:0] b);
      sm_type r;
      r.neg = (a < b);
      r.mag = r.neg ? b - a : a - b;
      return r;
   endfunction

   function automatic dir_type dir_of(pnt_type a, pnt_type b);
      dir_type d;
      d.dx = signed_diff(a.x, b.x);
      d.dy = signed_diff(a.y, b.y);
      return d;
   endfunction

   // Sign of a*b - c*d with exact 128-bit products.
   function automatic int product_sign(sm_type a, sm_type b, sm_type c, sm_type d);
      bit [127:0] p1, p2;
      int         s1, s2, u;
      p1 = {64'd0, a.mag} * {64'd0, b.mag};
      p2 = {64'd0, c.mag} * {64'd0, d.mag};
      s1 = (p1 == 0) ? 0 : ((a.neg ^ b.neg) ? -1 : 1);
      s2 = (p2 == 0) ? 0 : ((c.neg ^ d.neg) ? -1 : 1);
      if (s1 != s2) return (s1 < s2) ? -1 : 1;
      if (s1 == 0) return 0;
      u = (p1 < p2) ? -1 : ((p1 > p2) ? 1 : 0);
      return (s1 < 0) ? -u : u;
   endfunction

   function automatic int slope_order(dir_type p, dir_type q);
      return product_sign(p.dy, q.dx, p.dx, q.dy);
   endfunction

   function automatic int turn_dir(pnt_type o, pnt_type a, pnt_type b);
      dir_type oa, ob;
      oa = dir_of(a, o);
      ob = dir_of(b, o);
      return product_sign(oa.dx, ob.dy, oa.dy, ob.dx);
   endfunction

   function automatic pnt_type upper_pt(int i);
      pnt_type p;
      p.x = up_x[i];
      p.y = up_y[i];
      return p;
   endfunction

   function automatic pnt_type lower_pt(int i);
      pnt_type p;
      p.x = lo_x[i];
      p.y = lo_y[i];
      return p;
   endfunction

   function automatic pnt_type corner(int i);
      pnt_type p;
      p.x = cnx[i];
      p.y = cny[i];
      return p;
   endfunction

   function automatic void set_corner(int i, pnt_type p);
      cnx[i] = p.x;
      cny[i] = p.y;
   endfunction

   function automatic seg_result_type segment_snapshot(bit [1:0] status);
      seg_result_type r;
      r.status = status;
      r.points = seg_count;
      r.first_key = seg_first;
      for (int i = 0; i < 4; i++) begin
         r.cx[i] = cnx[i];
         r.cy[i] = cny[i];
      end
      return r;
   endfunction

   function automatic seg_result_type predict_point(bit [63:0] key, bit [63:0] pos);
      pnt_type  top, bot, c0, c1, c2, c3;
      dir_type  s1, s2, m, v;
      bit       full;
      int       best, tail;
      full = 1'b0;
      if (seg_count > 0 && key <= last_key) return segment_snapshot(ST_ORDER);
      last_key = key;
      top.x = key;
      bot.x = key;
      top.y = (pos >= ~64'd0 - band) ? ~64'd0 : pos + band;
      bot.y = (pos <= band) ? 64'd0 : pos - band;
      if (seg_count == 0) begin
         seg_first = key;
         set_corner(0, top); set_corner(1, bot); set_corner(2, top); set_corner(3, bot);
         up_x[0] = top.x; up_y[0] = top.y;
         lo_x[0] = bot.x; lo_y[0] = bot.y;
         up_base = 0; lo_base = 0;
         up_len = 1; lo_len = 1;
         seg_count = 1;
         return segment_snapshot(ST_ACCEPT);
      end
      if (seg_count == 1) begin
         set_corner(2, bot); set_corner(3, top);
         up_x[1] = top.x; up_y[1] = top.y;
         lo_x[1] = bot.x; lo_y[1] = bot.y;
         up_len = 2; lo_len = 2;
         seg_count = 2;
         return segment_snapshot(ST_ACCEPT);
      end
      c0 = corner(0); c1 = corner(1); c2 = corner(2); c3 = corner(3);
      s1 = dir_of(c2, c0);
      s2 = dir_of(c3, c1);
      if (slope_order(dir_of(top, c2), s1) < 0 || slope_order(dir_of(bot, c3), s2) > 0) begin
         seg_count = 0;
         return segment_snapshot(ST_CLOSE);
      end
      // Top end below the steepest line: tighten it against the lower hull.
      if (slope_order(dir_of(top, c1), s2) < 0) begin
         m = dir_of(lower_pt(lo_base), top);
         best = lo_base;
         for (int i = lo_base + 1; i < lo_len && i < HULL_DEPTH; i++) begin
            v = dir_of(lower_pt(i), top);
            if (slope_order(v, m) > 0) break;
            m = v;
            best = i;
         end
         set_corner(1, lower_pt(best));
         set_corner(3, top);
         lo_base = best;
         tail = up_len;
         while (tail >= up_base + 2 && turn_dir(upper_pt(tail - 2), upper_pt(tail - 1), top) <= 0)
            tail--;
         if (tail >= HULL_DEPTH) full = 1'b1;
         else begin
            up_x[tail] = top.x; up_y[tail] = top.y;
            up_len = tail + 1;
         end
      end
      if (!full && slope_order(dir_of(bot, c0), s1) > 0) begin
         m = dir_of(upper_pt(up_base), bot);
         best = up_base;
         for (int i = up_base + 1; i < up_len && i < HULL_DEPTH; i++) begin
            v = dir_of(upper_pt(i), bot);
            if (slope_order(v, m) < 0) break;
            m = v;
            best = i;
         end
         set_corner(0, upper_pt(best));
         set_corner(2, bot);
         up_base = best;
         tail = lo_len;
         while (tail >= lo_base + 2 && turn_dir(lower_pt(tail - 2), lower_pt(tail - 1), bot) >= 0)
            tail--;
         if (tail >= HULL_DEPTH) full = 1'b1;
         else begin
            lo_x[tail] = bot.x; lo_y[tail] = bot.y;
            lo_len = tail + 1;
         end
      end
      if (full) begin
         set_corner(0, c0); set_corner(1, c1); set_corner(2, c2); set_corner(3, c3);
         seg_count = 0;
         return segment_snapshot(ST_FULL);
      end
      if (seg_count != 32'hFFFF_FFFF) seg_count++;
      return segment_snapshot(ST_ACCEPT);
   endfunction

   function automatic void check_field(string name, bit [63:0] e, bit [63:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
         failed = 1'b1;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Item driver.
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_took)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_points.size() > 0) begin
            pnt_type p;
            p = pending_points.pop_front();
            req_valid <= 1'b1;
            req_key <= p.x;
            req_position <= p.y;
            send_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver; one long hold-off lets the block back up into its input.
   int stall_gap = 0;
   int hold_cycles = 0;
   int results_seen = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && results_seen >= 400) begin
            hold_done = 1'b1;
            hold_cycles = 600;
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (stall_gap > 0) begin
            rsp_stall <= 1'b1;
            stall_gap--;
         end else begin
            rsp_stall <= 1'b0;
            stall_gap = pick_gap();
         end
      end
   end

   // Monitor and checker.
   always @(posedge clock) begin
      seg_result_type got, want;
      if (!reset) begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_results.insert(expected_results.size(),
                                    predict_point(req_key, req_position));
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got.status = rsp_status;
            got.points = rsp_segment_points;
            got.first_key = rsp_first_key;
            got.cx = {rsp_corner3_x, rsp_corner2_x, rsp_corner1_x, rsp_corner0_x};
            got.cy = {rsp_corner3_y, rsp_corner2_y, rsp_corner1_y, rsp_corner0_y};
            if (expected_results.size() == 0) begin
               $display("%0t: result with no item outstanding, actual status %0d",
                        $time, got.status);
               failed = 1'b1;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 64'(want.status), 64'(got.status));
               check_field("segment_points", 64'(want.points), 64'(got.points));
               check_field("first_key", want.first_key, got.first_key);
               for (int i = 0; i < 4; i++) begin
                  check_field($sformatf("corner%0d_x", i), want.cx[i], got.cx[i]);
                  check_field($sformatf("corner%0d_y", i), want.cy[i], got.cy[i]);
               end
            end
         end
      end
   end

   // Watchdog on handshake progress.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_point(bit [63:0] key, bit [63:0] pos);
      pnt_type p;
      p.x = key;
      p.y = pos;
      pending_points.insert(pending_points.size(), p);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_points.size() > 0 || req_valid || expected_results.size() > 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_band(bit [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_error_bound <= value;
      do @(posedge clock);
      while (!csr_ready);
      band = {32'd0, value};
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Runs of points with steadily rising keys and roughly linear positions,
   // sprinkled with out-of-order keys and wild positions.
   task automatic random_points(int count);
      bit [63:0] pos, dk, slope;
      int        run, jr, r;
      while (count > 0) begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(2, 30);
         r = $urandom_range(0, 5);
         pos = (r == 0) ? 64'd0 : (r == 1) ? ~64'd0 - $urandom_range(0, 20)
                                          : {$urandom, $urandom};
         slope = 64'($urandom_range(0, 4));
         jr = $urandom_range(0, 40);
         for (int i = 0; i < run && count > 0; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               send_point(key_cursor - $urandom_range(0, 3), {$urandom, $urandom});
            end else begin
               dk = 64'($urandom_range(1, 1 << $urandom_range(0, 20)));
               key_cursor += dk;
               pos += dk * slope + $urandom_range(0, 2 * jr) - jr;
               if (r < 9) begin
                  send_point(key_cursor, {$urandom, $urandom});
                  if ($urandom_range(0, 1)) send_point(key_cursor, {$urandom, $urandom});
               end else begin
                  send_point(key_cursor, pos);
               end
            end
            count--;
         end
      end
   endtask

   initial begin
      bit [31:0] band_values[5];
      band_values = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1000, 32'd0};
      band_values[4] = $urandom;
      band = {32'd0, ERROR_BOUND_RESET};
      seg_count = 0;
      seg_first = 0;
      last_key = 0;
      up_base = 0; lo_base = 0; up_len = 0; lo_len = 0;
      for (int i = 0; i < 4; i++) begin
         cnx[i] = 0;
         cny[i] = 0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed points at the reset band: saturation, order errors, closes.
      send_point(64'd0, 64'd0);
      send_point(64'd6, 64'd3);
      send_point(64'd7, 64'd6);
      send_point(64'd7, 64'd9);
      send_point(64'd3, 64'd9);
      send_point(64'd8, ~64'd0);
      send_point(64'd8, ~64'd0);
      send_point(64'd9, ~64'd0 - 5);
      send_point(64'd10, ~64'd0 - 10);
      send_point(64'd11, ~64'd0 - 3);
      send_point(64'd12, 64'd0);
      send_point(64'd12, 64'd0);
      send_point(64'd13, 64'd1);
      send_point(64'd14, 64'd2);
      send_point(64'd15, 64'd3);
      send_point(64'd16, 64'd100);
      send_point(64'd16, 64'd100);
      send_point(64'd17, 64'd80);
      send_point(64'd18, 64'd120);
      send_point(64'd19, 64'd60);
      send_point(64'd20, 64'd140);
      key_cursor = 64'd20;
      wait_drained();

      for (int ph = 0; ph < 5; ph++) begin
         write_band(band_values[ph]);
         burst_mode = (ph == 2);
         if (key_cursor < (64'(ph + 1) << 61))
            key_cursor = (64'(ph + 1) << 61) + {$urandom_range(0, 255), $urandom};
         random_points(376);
         wait_drained();
      end

      // Keys at the top of the range can only end the run.
      burst_mode = 1'b0;
      key_cursor = ~64'd0 - 64'd100;
      send_point(key_cursor, 64'd50);
      send_point(key_cursor + 1, 64'd50);
      send_point(~64'd0, 64'd0);
      send_point(~64'd0, ~64'd0);
      wait_drained();

      if (!failed) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
